[rtl/nbm_pkg.sv]
// Package for the NFA byte matcher: sizes, operation and kind codes,
// request, response and table entry types, sequencer states.
// No dependencies.
`default_nettype none

package nbm_pkg;

    localparam int NFA_STATES = 64;
    localparam int IDX_W      = $clog2(NFA_STATES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NFA_STATES - 1);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_BEGIN   = 2'd1;
    localparam logic [1:0] OP_CONSUME = 2'd2;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_SPLIT = 2'd1;
    localparam logic [1:0] KIND_MATCH = 2'd2;

    localparam logic REG_START_STATE = 1'b0;
    localparam logic REG_START_VALID = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] entry_index;
        logic [1:0] entry_kind;
        logic [7:0] entry_char;
        logic [5:0] entry_next;
        logic       entry_next_valid;
        logic [5:0] entry_alt;
        logic       entry_alt_valid;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic matched;
        logic any_active;
    } t_out_rsp;

    typedef struct packed {
        logic [7:0] chr;
        logic [5:0] next;
        logic       next_valid;
        logic [5:0] alt;
        logic       alt_valid;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_CLOSE,
        ST_CLOSE_DRAIN,
        ST_FLAGS
    } t_state;

endpackage

`default_nettype wire

[rtl/nfa_byte_matcher.sv]
// Thompson NFA matcher top level: request/response channels, APB-style
// configuration port, sweep sequencer over the state table.
// Depends on nbm_pkg and nbm_ram.
//
// Usage: a request carries an operation. A write stores one table entry, a
// begin loads the active set with the closure of the start state, a consume
// advances the active set over one data byte. Each request returns one
// response with the matched and any_active flags of the active set after it.
// A request is taken when i_in_valid is high and o_in_stall is low; a
// response is taken when o_out_valid is high and i_out_stall is low.
// The table sits in a 64-entry RAM read one entry per cycle by a single
// sweep counter; the kind of each entry is also kept in flip-flops.
// Sequence: a write or unknown operation goes straight to the flags state. A
// begin runs closure passes; a consume runs a transition sweep and then
// closure passes. A pass repeats while any state still waits for expansion
// (one more pass for each epsilon edge in the chain that points back or to
// the very next entry, at most one per state).
// The block takes one request at a time; a finished response waits in the
// output register while the next request is accepted and worked on.
// Reset empties the active set, clears both configuration registers and the
// output valid; table contents are unknown until written.
`default_nettype none

module nfa_byte_matcher (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire nbm_pkg::t_in_req                i_in_req,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output nbm_pkg::t_out_rsp                    o_out_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nbm_pkg::CFG_AW-1:0]      paddr,
    input  wire logic [nbm_pkg::CFG_DW-1:0]      pwdata,
    output logic      [nbm_pkg::CFG_DW-1:0]      prdata,
    output logic                                 pready
);

    nbm_pkg::t_state                     r_state, n_state;
    logic [nbm_pkg::IDX_W-1:0]           r_idx, n_idx;
    logic [nbm_pkg::NFA_STATES-1:0]      r_active, n_active;
    logic [nbm_pkg::NFA_STATES-1:0]      r_dst, n_dst;
    logic [nbm_pkg::NFA_STATES-1:0]      r_seen, n_seen;
    logic [nbm_pkg::NFA_STATES-1:0]      r_pend, n_pend;
    logic [nbm_pkg::NFA_STATES-1:0]      r_is_char, n_is_char;
    logic [nbm_pkg::NFA_STATES-1:0]      r_is_split, n_is_split;
    logic [nbm_pkg::NFA_STATES-1:0]      r_is_match, n_is_match;
    logic                                r_proc, n_proc;
    logic [7:0]                          r_byte, n_byte;
    logic                                r_out_valid, n_out_valid;
    nbm_pkg::t_out_rsp                   r_out, n_out;
    logic [5:0]                          r_start_state;
    logic                                r_start_valid;

    logic                                in_accept;
    logic                                scan_mode;
    logic                                wr_en;
    nbm_pkg::t_entry                     wr_entry;
    nbm_pkg::t_entry                     rd_entry;
    logic [nbm_pkg::ENTRY_W-1:0]         rd_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign scan_mode = (r_state == nbm_pkg::ST_SCAN) || (r_state == nbm_pkg::ST_SCAN_DRAIN);

    assign wr_entry.chr        = i_in_req.entry_char;
    assign wr_entry.next       = i_in_req.entry_next;
    assign wr_entry.next_valid = i_in_req.entry_next_valid;
    assign wr_entry.alt        = i_in_req.entry_alt;
    assign wr_entry.alt_valid  = i_in_req.entry_alt_valid;
    assign rd_entry            = nbm_pkg::t_entry'(rd_data);

    nbm_ram #(
        .WIDTH (nbm_pkg::ENTRY_W),
        .DEPTH (nbm_pkg::NFA_STATES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_req.entry_index),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_active    = r_active;
        n_dst       = r_dst;
        n_seen      = r_seen;
        n_pend      = r_pend;
        n_is_char   = r_is_char;
        n_is_split  = r_is_split;
        n_is_match  = r_is_match;
        n_proc      = 1'b0;
        n_byte      = r_byte;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // expand the entry read in the previous cycle
        if (r_proc) begin
            if (scan_mode) begin
                if (rd_entry.chr == r_byte && rd_entry.next_valid &&
                    !n_seen[rd_entry.next]) begin
                    n_seen[rd_entry.next] = 1'b1;
                    n_pend[rd_entry.next] = 1'b1;
                end
            end else begin
                if (rd_entry.next_valid && !n_seen[rd_entry.next]) begin
                    n_seen[rd_entry.next] = 1'b1;
                    n_pend[rd_entry.next] = 1'b1;
                end
                if (rd_entry.alt_valid && !n_seen[rd_entry.alt]) begin
                    n_seen[rd_entry.alt] = 1'b1;
                    n_pend[rd_entry.alt] = 1'b1;
                end
            end
        end

        case (r_state)
            nbm_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (i_in_req.operation)
                        nbm_pkg::OP_WRITE: begin
                            wr_en = 1'b1;
                            n_is_char[i_in_req.entry_index] =
                                (i_in_req.entry_kind == nbm_pkg::KIND_CHAR);
                            n_is_split[i_in_req.entry_index] =
                                (i_in_req.entry_kind == nbm_pkg::KIND_SPLIT);
                            n_is_match[i_in_req.entry_index] =
                                (i_in_req.entry_kind == nbm_pkg::KIND_MATCH);
                            n_state = nbm_pkg::ST_FLAGS;
                        end
                        nbm_pkg::OP_BEGIN: begin
                            n_dst  = '0;
                            n_seen = '0;
                            n_pend = '0;
                            if (r_start_valid) begin
                                n_seen[r_start_state] = 1'b1;
                                n_pend[r_start_state] = 1'b1;
                            end
                            n_state = nbm_pkg::ST_CLOSE_DRAIN;
                        end
                        nbm_pkg::OP_CONSUME: begin
                            n_byte  = i_in_req.data_byte;
                            n_dst   = '0;
                            n_seen  = '0;
                            n_pend  = '0;
                            n_idx   = '0;
                            n_state = nbm_pkg::ST_SCAN;
                        end
                        default: begin
                            n_state = nbm_pkg::ST_FLAGS;
                        end
                    endcase
                end
            end
            nbm_pkg::ST_SCAN: begin
                n_proc = r_active[r_idx] && r_is_char[r_idx];
                n_idx  = r_idx + nbm_pkg::IDX_W'(1);
                if (r_idx == nbm_pkg::LAST_IDX) begin
                    n_state = nbm_pkg::ST_SCAN_DRAIN;
                end
            end
            nbm_pkg::ST_CLOSE: begin
                if (r_pend[r_idx]) begin
                    n_pend[r_idx] = 1'b0;
                    if (r_is_split[r_idx]) begin
                        n_proc = 1'b1;
                    end else begin
                        n_dst[r_idx] = 1'b1;
                    end
                end
                n_idx = r_idx + nbm_pkg::IDX_W'(1);
                if (r_idx == nbm_pkg::LAST_IDX) begin
                    n_state = nbm_pkg::ST_CLOSE_DRAIN;
                end
            end
            nbm_pkg::ST_SCAN_DRAIN, nbm_pkg::ST_CLOSE_DRAIN: begin
                if (n_pend != '0) begin
                    n_idx   = '0;
                    n_state = nbm_pkg::ST_CLOSE;
                end else begin
                    n_active = n_dst;
                    n_state  = nbm_pkg::ST_FLAGS;
                end
            end
            nbm_pkg::ST_FLAGS: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.matched    = |(r_active & r_is_match);
                    n_out.any_active = |r_active;
                    n_out_valid      = 1'b1;
                    n_state          = nbm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nbm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nbm_pkg::ST_IDLE;
            r_active    <= '0;
            r_proc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_proc      <= n_proc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_dst      <= n_dst;
        r_seen     <= n_seen;
        r_pend     <= n_pend;
        r_is_char  <= n_is_char;
        r_is_split <= n_is_split;
        r_is_match <= n_is_match;
        r_byte     <= n_byte;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_start_valid <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                nbm_pkg::REG_START_STATE: r_start_state <= pwdata[5:0];
                nbm_pkg::REG_START_VALID: r_start_valid <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            nbm_pkg::REG_START_STATE: prdata = {(nbm_pkg::CFG_DW - 6)'(0), r_start_state};
            nbm_pkg::REG_START_VALID: prdata = {(nbm_pkg::CFG_DW - 1)'(0), r_start_valid};
            default:                  prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != nbm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

`default_nettype wire

[rtl/nbm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module nbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/nbm_checker.sv]
// Port-level checker for the NFA byte matcher, bound to the top level.
// Depends on nbm_pkg and nfa_byte_matcher.
`default_nettype none

module nbm_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire nbm_pkg::t_out_rsp o_out_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("response changed while stalled");

    a_match_implies_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_rsp.matched && !o_out_rsp.any_active))
        else $error("matched without any active state");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted but block not busy");

    a_response_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("response appeared without a request in flight");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

endmodule

bind nfa_byte_matcher nbm_checker u_nbm_checker (.*);

`default_nettype wire
